// ===== rtl/olrb_pkg.sv =====
package olrb_pkg;

	localparam int LOG_DEPTH_DEF = 16384;
	localparam int MAX_READ_DEF  = 64;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 7;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_READ   = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic append;
		logic load;
		logic issue;
	} olrb_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic rem_zero;
		logic rem_one;
	} olrb_sts_t;

endpackage

// ===== rtl/olrb_ram.sv =====
module olrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/olrb_dp.sv =====
module olrb_dp
	import olrb_pkg::*;
#(
	parameter int LOG_DEPTH = LOG_DEPTH_DEF,
	parameter int MAX_READ  = MAX_READ_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  olrb_cmd_t         cmd,
	output olrb_sts_t         sts,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic [LEN_W-1:0]  read_length,
	output logic [BYTE_W-1:0] read_byte,
	output logic              is_last,
	output logic              is_empty,
	output logic [LEN_W-1:0]  returned_count
);

	localparam int PTR_W = $clog2(LOG_DEPTH);
	localparam int CNT_W = $clog2(LOG_DEPTH + 1);
	localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam int SUB_W = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;

	logic [PTR_W-1:0]  wp_q;
	logic [CNT_W-1:0]  fill_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [LEN_W-1:0]  rem_q;
	logic [LEN_W-1:0]  count_q;
	logic              last_q;
	logic              empty_q;
	logic [LEN_W-1:0]  count_out_q;
	logic [BYTE_W-1:0] ram_rdata;

	logic [LEN_W-1:0]  want;
	logic [LEN_W-1:0]  n_rd;
	logic [SUB_W-1:0]  wp_ext;
	logic [SUB_W-1:0]  n_ext;
	logic [SUB_W-1:0]  start_ext;

	// clamp request, then limit by what is stored
	always_comb begin
		want = (read_length > LEN_W'(MAX_READ)) ? LEN_W'(MAX_READ) : read_length;
		if (CMP_W'(fill_q) < CMP_W'(want)) begin
			n_rd = LEN_W'(fill_q);
		end else begin
			n_rd = want;
		end
		wp_ext = SUB_W'(wp_q);
		n_ext  = SUB_W'(n_rd);
		if (wp_ext >= n_ext) begin
			start_ext = wp_ext - n_ext;
		end else begin
			start_ext = wp_ext + SUB_W'(LOG_DEPTH) - n_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (cmd.append) begin
			wp_q <= (wp_q == PTR_W'(LOG_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (fill_q != CNT_W'(LOG_DEPTH)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_ptr_q <= start_ext[PTR_W-1:0];
			rem_q    <= n_rd;
			count_q  <= n_rd;
		end else if (cmd.issue) begin
			rd_ptr_q <= (rd_ptr_q == PTR_W'(LOG_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (rem_q != '0) begin
				rem_q <= rem_q - 1'b1;
			end
		end
		if (cmd.issue) begin
			last_q      <= sts.rem_zero | sts.rem_one;
			empty_q     <= sts.rem_zero;
			count_out_q <= count_q;
		end
	end

	olrb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(LOG_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.append),
		.waddr(wp_q),
		.wdata(data_byte),
		.re   (cmd.issue),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	assign sts.rem_zero   = (rem_q == '0);
	assign sts.rem_one    = (rem_q == LEN_W'(1));
	assign read_byte      = empty_q ? '0 : ram_rdata;
	assign is_last        = last_q;
	assign is_empty       = empty_q;
	assign returned_count = count_out_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(LOG_DEPTH))
		else $error("fill count above depth");

	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (rem_q <= LEN_W'(MAX_READ)) && (rem_q == count_q))
		else $error("read length not clamped");

endmodule

// ===== rtl/olrb_ctrl.sv =====
module olrb_ctrl
	import olrb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      operation,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  olrb_sts_t sts,
	output olrb_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   in_acc;

	assign in_stall   = (state_q != S_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign cmd.append = in_acc && (operation == OP_APPEND);
	assign cmd.load   = in_acc && (operation == OP_READ);
	// next byte goes out when the output slot is free or drains this cycle
	assign cmd.issue  = (state_q == S_READ) && (!out_valid_q || !out_stall);
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.issue) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (cmd.issue && (sts.rem_zero || sts.rem_one)) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue && (sts.rem_zero || sts.rem_one) |=> !in_stall)
		else $error("input not released after last item");

	a_load_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> in_stall && !cmd.append)
		else $error("read not started");

	a_issue_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |=> out_valid)
		else $error("issued item not presented");

endmodule

// ===== rtl/overwriting_log_ring_buffer.sv =====
// channel | valid     | stall     | payload
// input   | in_valid  | in_stall  | operation, data_byte, message_end, read_length
// output  | out_valid | out_stall | read_byte, is_last, is_empty, returned_count
//
// Appends can follow back to back.
// A read is set up when it is accepted, then streams one item per cycle while out_stall
// is low, from the log RAM's registered read port; an empty log gives a single item marked is_empty.
// Input is stalled while a read streams; out_stall holds the RAM read.
// Reset clears pointer, fill count and control; log contents are not cleared.
module overwriting_log_ring_buffer
	import olrb_pkg::*;
#(
	parameter int LOG_DEPTH = LOG_DEPTH_DEF,
	parameter int MAX_READ  = MAX_READ_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              operation,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              message_end,
	input  logic [LEN_W-1:0]  read_length,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] read_byte,
	output logic              is_last,
	output logic              is_empty,
	output logic [LEN_W-1:0]  returned_count
);

	olrb_cmd_t cmd;
	olrb_sts_t sts;

	olrb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.operation(operation),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	olrb_dp #(
		.LOG_DEPTH(LOG_DEPTH),
		.MAX_READ (MAX_READ)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.data_byte     (data_byte),
		.read_length   (read_length),
		.read_byte     (read_byte),
		.is_last       (is_last),
		.is_empty      (is_empty),
		.returned_count(returned_count)
	);

	// message_end is a framing mark only; storage ignores it
	a_no_mark_effect: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && message_end && (operation == OP_APPEND) |=> !out_valid
		|| $past(out_valid))
		else $error("append produced an item");

endmodule
